@@ hw/rtl/spa_pkg.sv @@
// ----------------------------------------------------------------------------
// spa_pkg: shared types and codes for the sparse polynomial adder
// Item structs, command codes and stored term layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spa_pkg;

  localparam int COEF_W = 16;
  localparam int EXP_W  = 16;
  localparam int SUM_W  = COEF_W + 1;
  localparam int TERM_W = COEF_W + EXP_W;

  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_ADD         = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [COEF_W-1:0] coefficient;
    logic [EXP_W-1:0]         exponent;
  } spa_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_coefficient;
    logic [EXP_W-1:0]        term_exponent;
    logic                    last_term;
    logic                    empty_result;
    logic                    terms_dropped;
  } spa_out_t;

  // Status from the merge sequencer to the list control
  typedef struct packed {
    logic busy;
    logic done;
  } spa_stat_t;

endpackage

@@ hw/rtl/sparse_polynomial_add_top.sv @@
// ----------------------------------------------------------------------------
// sparse_polynomial_add_top: sparse polynomial adder (sorted-list merge)
// Usage: items on in_data (valid/ready) carry a command. A load command
// appends one term to the first or second list; a load into a
// full list is dropped and raises the dropped flag. An add command merges
// both lists by descending exponent and emits one out_data item per result
// term, last_term on the final one; with both lists empty it emits a single
// item flagged empty_result. Lists and the dropped flag clear after an add.
// Sequence: each result term takes a RAM read state, then a compare/add
// state through the shared unit; in_ready stays low until the add is done.
// The output register lets a load or the next add be taken while the last
// result still waits. A receiver stall holds out_data and freezes the merge.
// Reset: rst_n (synchronous, active low) empties both lists and the flag;
// list storage is not cleared, entries are only read after being written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_polynomial_add_top
  import spa_pkg::*;
#(
  parameter int MAX_TERMS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  spa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output spa_out_t out_data
);

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_TERMS);

  logic [CNT_W-1:0]  cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic              ovf_r, ovf_nxt;
  logic              in_fire, we_a, we_b, start;
  logic [TERM_W-1:0] wdata, rd_a, rd_b;
  logic [IDX_W-1:0]  raddr_a, raddr_b;
  spa_stat_t         stat;

  // Accept items only while the merge sequencer is idle
  assign in_ready = !stat.busy;
  assign in_fire  = in_valid && in_ready;
  assign wdata    = {in_data.coefficient, in_data.exponent};

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ovf_nxt   = ovf_r;
    we_a      = 1'b0;
    we_b      = 1'b0;
    start     = 1'b0;
    if (stat.done) begin
      // Drop both lists and the flag once the final result is loaded
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (in_fire) begin
      case (in_data.command)
        CMD_LOAD_FIRST: begin
          if (cnt_a_r == FULL) begin
            ovf_nxt = 1'b1;
          end else begin
            we_a      = 1'b1;
            cnt_a_nxt = cnt_a_r + 1'b1;
          end
        end
        CMD_LOAD_SECOND: begin
          if (cnt_b_r == FULL) begin
            ovf_nxt = 1'b1;
          end else begin
            we_b      = 1'b1;
            cnt_b_nxt = cnt_b_r + 1'b1;
          end
        end
        CMD_ADD: begin
          start = 1'b1;
        end
        default: begin
          // unknown command: take the item, change nothing
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  spa_ram #(
    .WIDTH(TERM_W),
    .DEPTH(MAX_TERMS)
  ) u_ram_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(cnt_a_r[IDX_W-1:0]),
    .wdata(wdata),
    .raddr(raddr_a),
    .rdata(rd_a)
  );

  spa_ram #(
    .WIDTH(TERM_W),
    .DEPTH(MAX_TERMS)
  ) u_ram_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(cnt_b_r[IDX_W-1:0]),
    .wdata(wdata),
    .raddr(raddr_b),
    .rdata(rd_b)
  );

  spa_merge #(
    .MAX_TERMS(MAX_TERMS)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cnt_a    (cnt_a_r),
    .cnt_b    (cnt_b_r),
    .dropped  (ovf_r),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Counts never pass the list depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= FULL && cnt_b_r <= FULL)
    else $error("list count beyond depth");

  // Finishing an add empties both lists and the dropped flag
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> (cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r))
    else $error("lists not cleared after add");

  // An empty result is always the only, and so the last, item of its add
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_result |-> out_data.last_term)
    else $error("empty result without last marker");

  // Lists do not change while a merge is in progress
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy && !stat.done |=> $stable(cnt_a_r) && $stable(cnt_b_r))
    else $error("list changed during merge");

endmodule

@@ hw/rtl/spa_ram.sv @@
// ----------------------------------------------------------------------------
// spa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/spa_merge.sv @@
// ----------------------------------------------------------------------------
// spa_merge: merge sequencer for two sorted term lists
// Fetches one term from each list, compares exponents, adds coefficients
// in one shared unit and loads the output register, one term per pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spa_merge
  import spa_pkg::*;
#(
  parameter int MAX_TERMS = 16,
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int CNT_W = $clog2(MAX_TERMS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CNT_W-1:0]  cnt_a,
  input  logic [CNT_W-1:0]  cnt_b,
  input  logic              dropped,
  input  logic [TERM_W-1:0] rd_a,
  input  logic [TERM_W-1:0] rd_b,
  output logic [IDX_W-1:0]  raddr_a,
  output logic [IDX_W-1:0]  raddr_b,
  output spa_stat_t         stat,
  output logic              out_valid,
  input  logic              out_ready,
  output spa_out_t          out_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_EMPTY = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic             out_valid_r, out_valid_nxt;
  spa_out_t         out_data_r, out_data_nxt;

  logic                    a_has, b_has, a_gt, ex_eq, take_a, take_b;
  logic signed [SUM_W-1:0] opnd_a, opnd_b, sum;
  logic [EXP_W-1:0]        ex_a, ex_b, ex_sel;
  logic [CNT_W-1:0]        i_adv, j_adv;
  logic                    last, out_free, done;

  assign ex_a  = rd_a[EXP_W-1:0];
  assign ex_b  = rd_b[EXP_W-1:0];
  assign a_has = i_r < cnt_a;
  assign b_has = j_r < cnt_b;
  assign a_gt  = ex_a > ex_b;
  assign ex_eq = ex_a == ex_b;

  assign take_a = a_has && (!b_has || a_gt || ex_eq);
  assign take_b = b_has && (!a_has || !a_gt);

  // Shared adder: an untaken side contributes zero
  assign opnd_a = take_a ? SUM_W'(signed'(rd_a[TERM_W-1:EXP_W])) : '0;
  assign opnd_b = take_b ? SUM_W'(signed'(rd_b[TERM_W-1:EXP_W])) : '0;
  assign sum    = opnd_a + opnd_b;
  assign ex_sel = take_a ? ex_a : ex_b;

  assign i_adv = i_r + CNT_W'(take_a);
  assign j_adv = j_r + CNT_W'(take_b);
  assign last  = (i_adv == cnt_a) && (j_adv == cnt_b);

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    done          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = (cnt_a == '0 && cnt_b == '0) ? S_EMPTY : S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.sum_coefficient = sum;
          out_data_nxt.term_exponent   = ex_sel;
          out_data_nxt.last_term       = last;
          out_data_nxt.empty_result    = 1'b0;
          out_data_nxt.terms_dropped   = dropped;
          i_nxt                        = i_adv;
          j_nxt                        = j_adv;
          if (last) begin
            state_nxt = S_IDLE;
            done      = 1'b1;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.sum_coefficient = '0;
          out_data_nxt.term_exponent   = '0;
          out_data_nxt.last_term       = 1'b1;
          out_data_nxt.empty_result    = 1'b1;
          out_data_nxt.terms_dropped   = dropped;
          state_nxt                    = S_IDLE;
          done                         = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Pointer equal to the depth only occurs past the end; that read is unused
  assign raddr_a   = i_r[IDX_W-1:0];
  assign raddr_b   = j_r[IDX_W-1:0];
  assign stat.busy = state_r != S_IDLE;
  assign stat.done = done;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/tb_sparse_polynomial_add_top.sv @@
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_add_top: self-checking bench for the sparse adder
// Loads two term lists item by item, issues add commands and checks every
// result item against a merge predictor kept in the bench. Runs directed
// corner cases, a long output stall, a drain pause and random merges under
// several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sparse_polynomial_add_top;
  import spa_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int LIST_DEPTH   = 16;
  localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
  localparam int SETTLE_CYCLES = 20;   // quiet time after the last result
  localparam int PRINT_LIMIT  = 200;
  localparam int RANDOM_ITEMS_PER_PHASE = 80;
  localparam int LONG_HOLD    = 300;

  // Command code the block has no use for: it must be ignored
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  spa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  spa_out_t out_data;

  // Pacing knobs: idle and stall chances in percent per cycle, and a hold length
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  int error_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  // Predictor state: the two term lists and the drop flag
  logic signed [COEF_W-1:0] first_coefs [LIST_DEPTH];
  logic [EXP_W-1:0]         first_exps [LIST_DEPTH];
  logic signed [COEF_W-1:0] second_coefs [LIST_DEPTH];
  logic [EXP_W-1:0]         second_exps [LIST_DEPTH];
  int                       first_len = 0;
  int                       second_len = 0;
  logic                     dropped_flag = 1'b0;

  // Result items the block still owes, oldest first
  spa_out_t expected_terms[$];

  sparse_polynomial_add_top #(
    .MAX_TERMS(LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Apply one accepted item to the predictor and queue the results it causes
  task automatic predict_sum(input spa_in_t item);
    int i;
    int j;
    spa_out_t r;
    logic signed [SUM_W-1:0] ca;
    logic signed [SUM_W-1:0] cb;
    i = 0;
    j = 0;
    case (item.command)
      CMD_LOAD_FIRST: begin
        if (first_len < LIST_DEPTH) begin
          first_coefs[first_len] = item.coefficient;
          first_exps[first_len] = item.exponent;
          first_len++;
        end else begin
          dropped_flag = 1'b1;
        end
      end
      CMD_LOAD_SECOND: begin
        if (second_len < LIST_DEPTH) begin
          second_coefs[second_len] = item.coefficient;
          second_exps[second_len] = item.exponent;
          second_len++;
        end else begin
          dropped_flag = 1'b1;
        end
      end
      CMD_ADD: begin
        if (first_len == 0 && second_len == 0) begin
          r = '0;
          r.last_term = 1'b1;
          r.empty_result = 1'b1;
          r.terms_dropped = dropped_flag;
          expected_terms.push_back(r);
        end else begin
          while (i < first_len || j < second_len) begin
            r = '0;
            r.terms_dropped = dropped_flag;
            if (i < first_len && j < second_len && first_exps[i] == second_exps[j]) begin
              // equal exponents fold into one term, even when the sum is zero
              ca = first_coefs[i];
              cb = second_coefs[j];
              r.sum_coefficient = ca + cb;
              r.term_exponent = first_exps[i];
              i++;
              j++;
            end else if (i < first_len && (j >= second_len || first_exps[i] > second_exps[j])) begin
              r.sum_coefficient = first_coefs[i];
              r.term_exponent = first_exps[i];
              i++;
            end else begin
              r.sum_coefficient = second_coefs[j];
              r.term_exponent = second_exps[j];
              j++;
            end
            r.last_term = (i >= first_len && j >= second_len);
            expected_terms.push_back(r);
          end
        end
        first_len = 0;
        second_len = 0;
        dropped_flag = 1'b0;
      end
      default: begin
        // unused command code: no result, no state change
      end
    endcase
  endtask

  function automatic spa_in_t make_item(input logic [1:0] cmd, input logic [COEF_W-1:0] coef,
                                        input logic [EXP_W-1:0] expo);
    spa_in_t it;
    it.command = cmd;
    it.coefficient = coef;
    it.exponent = expo;
    return it;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coefficient();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // A span of zero draws from the full exponent range; a small span forces
  // many equal exponents across the two lists
  function automatic logic [EXP_W-1:0] pick_exponent(input int span);
    if (span == 0) begin
      return EXP_W'($urandom_range(65535));
    end
    return EXP_W'($urandom_range(span));
  endfunction

  // Offer one item, hold it until accepted, then feed the predictor.
  // Valid is never lowered on acceptance: a back-to-back item keeps it high,
  // and an idle gap lowers it in a step of its own.
  task automatic send_item(input spa_in_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.command != CMD_UNUSED) items_sent++;
    predict_sum(item);
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_terms.size() != 0) @(posedge clk);
  endtask

  // Build two term lists, load them interleaved with some noise, then add
  task automatic send_polynomial_pair(input int n1, input int n2, input bit sorted,
                                      input int span);
    logic [EXP_W-1:0]  fe[$];
    logic [EXP_W-1:0]  se[$];
    logic [COEF_W-1:0] fc[$];
    logic [COEF_W-1:0] sc[$];
    int k;
    bit take_first;
    for (k = 0; k < n1; k++) begin
      fe.push_back(pick_exponent(span));
      fc.push_back(pick_coefficient());
    end
    for (k = 0; k < n2; k++) begin
      if (fe.size() > 0 && $urandom_range(9) < 4) begin
        se.push_back(fe[$urandom_range(fe.size() - 1)]);
      end else begin
        se.push_back(pick_exponent(span));
      end
      sc.push_back(pick_coefficient());
    end
    if (sorted) begin
      fe.rsort();
      se.rsort();
    end
    while (fe.size() > 0 || se.size() > 0) begin
      if ($urandom_range(19) == 0) begin
        send_item(make_item(CMD_UNUSED, COEF_W'($urandom), EXP_W'($urandom)));
      end
      take_first = (se.size() == 0) || (fe.size() > 0 && $urandom_range(1) == 1);
      if (take_first) begin
        send_item(make_item(CMD_LOAD_FIRST, fc.pop_front(), fe.pop_front()));
      end else begin
        send_item(make_item(CMD_LOAD_SECOND, sc.pop_front(), se.pop_front()));
      end
    end
    // payload of an add is don't-care: randomize it anyway
    send_item(make_item(CMD_ADD, COEF_W'($urandom), EXP_W'($urandom)));
  endtask

  // Extreme coefficients and exponents, a zero sum that must survive, and an
  // unused command slipped between loads
  task automatic test_extremes_and_cancel();
    send_item(make_item(CMD_LOAD_FIRST, 16'h7FFF, 16'hFFFF));
    send_item(make_item(CMD_LOAD_SECOND, 16'h7FFF, 16'hFFFF));
    send_item(make_item(CMD_LOAD_FIRST, 16'h8000, 16'h0001));
    send_item(make_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF));
    send_item(make_item(CMD_LOAD_SECOND, 16'h8000, 16'h0001));
    send_item(make_item(CMD_LOAD_FIRST, 16'hFFFF, 16'h0000));
    send_item(make_item(CMD_LOAD_SECOND, 16'h0001, 16'h0000));
    send_item(make_item(CMD_ADD, 16'h0000, 16'h0000));
  endtask

  // Both lists empty, twice in a row
  task automatic test_empty_add();
    send_item(make_item(CMD_ADD, 16'hFFFF, 16'hFFFF));
    send_item(make_item(CMD_ADD, 16'h0000, 16'h0000));
  endtask

  // One load past capacity: dropped, flag set on every result of the add
  task automatic test_list_overflow();
    int k;
    for (k = 0; k <= LIST_DEPTH; k++) begin
      send_item(make_item(CMD_LOAD_FIRST, pick_coefficient(), 16'(1000 - 3 * k)));
    end
    send_item(make_item(CMD_ADD, 16'h0000, 16'h0000));
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the
  // merge freezes and the input side backs up
  task automatic test_fill_and_stall();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = LONG_HOLD;
    send_polynomial_pair(LIST_DEPTH, LIST_DEPTH, 1'b1, 0);
    send_polynomial_pair(4, 2, 1'b1, 63);
  endtask

  // Pause the sender until the block has delivered everything, then go on
  task automatic test_pause_for_drain();
    send_idle_pct = 28;
    recv_stall_pct = 28;
    send_polynomial_pair(3, 3, 1'b1, 63);
    wait_for_results();
    send_polynomial_pair(2, 0, 1'b1, 0);
    wait_for_results();
  endtask

  // Mostly sorted lists with random content; some unsorted, some overflowing
  task automatic test_random_merges();
    int send_mix[4] = '{0, 50, 0, 28};
    int recv_mix[4] = '{0, 0, 50, 28};
    int p;
    int start;
    int kind;
    int n1;
    int n2;
    for (p = 0; p < 4; p++) begin
      send_idle_pct = send_mix[p];
      recv_stall_pct = recv_mix[p];
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS_PER_PHASE) begin
        kind = $urandom_range(99);
        n1 = $urandom_range(LIST_DEPTH);
        n2 = $urandom_range(LIST_DEPTH);
        if (kind < 8) begin
          if ($urandom_range(1) == 1) n1 = LIST_DEPTH + $urandom_range(1, 2);
          else n2 = LIST_DEPTH + $urandom_range(1, 2);
        end
        send_polynomial_pair(n1, n2, kind >= 18, ($urandom_range(1) == 1) ? 63 : 0);
      end
    end
  endtask

  // Receiver pacing: a requested hold wins, else stall at the phase rate
  always @(posedge clk) begin : receiver_pacing
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin : result_checker
    spa_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_terms.size() == 0) begin
        report_error($sformatf("result item with none expected: coef %0d exp %0d",
                               out_data.sum_coefficient, out_data.term_exponent));
      end else begin
        want = expected_terms.pop_front();
        if (out_data.sum_coefficient !== want.sum_coefficient)
          report_error($sformatf("sum_coefficient %0d, want %0d",
                                 out_data.sum_coefficient, want.sum_coefficient));
        if (out_data.term_exponent !== want.term_exponent)
          report_error($sformatf("term_exponent %0d, want %0d",
                                 out_data.term_exponent, want.term_exponent));
        if (out_data.last_term !== want.last_term)
          report_error($sformatf("last_term %b, want %b", out_data.last_term, want.last_term));
        if (out_data.empty_result !== want.empty_result)
          report_error($sformatf("empty_result %b, want %b",
                                 out_data.empty_result, want.empty_result));
        if (out_data.terms_dropped !== want.terms_dropped)
          report_error($sformatf("terms_dropped %b, want %b",
                                 out_data.terms_dropped, want.terms_dropped));
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no handshake for %0d cycles", STALL_LIMIT);
      $display("sparse_polynomial_add_top test failed");
      $finish;
    end
  end

  initial begin
    // hold reset, then release it once
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes_and_cancel();
    test_empty_add();
    test_list_overflow();
    test_fill_and_stall();
    test_pause_for_drain();
    test_random_merges();

    // drain, then give the block time to show any stray result
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_terms.size() != 0) begin
      report_error($sformatf("%0d result items never arrived", expected_terms.size()));
    end
    if (error_count == 0) begin
      $display("sparse_polynomial_add_top test passed");
    end else begin
      $display("sparse_polynomial_add_top test failed");
    end
    $finish;
  end

endmodule
